// File: hdl/assert_macros.svh
// Assertion macros shared by the block's modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");

`endif

// File: hdl/grcw_pkg.sv
// Shared types and codes for the Givens rotation wavefront block
package grcw_pkg;

    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 40;

    localparam logic [1:0] ACT_PRIME  = 2'd0;
    localparam logic [1:0] ACT_ROTATE = 2'd1;
    localparam logic [1:0] ACT_DRAIN  = 2'd2;

    localparam logic [1:0] ACC_HOLD     = 2'd0;
    localparam logic [1:0] ACC_LOAD_ADD = 2'd1;
    localparam logic [1:0] ACC_LOAD_SUB = 2'd2;
    localparam logic [1:0] ACC_ADD      = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       mem_we;
        logic       wr_src_acc;
        logic [1:0] wr_idx;
        logic       mem_re;
        logic [1:0] rd_idx;
        logic [1:0] coef_sel;
        logic       mul_sin;
        logic       mul_t;
        logic [1:0] acc_op;
        logic       tn_load;
        logic       t_load;
        logic       out_load;
        logic       out_from_t;
        logic [1:0] out_pos;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       row_ok;
        logic [1:0] slot;
        logic       slot_ok;
        logic [1:0] eff_len;
        logic       out_free;
    } t_status;

endpackage

// File: hdl/grcw_ctrl.sv
// Sequencer for prime, rotate and drain items
`include "assert_macros.svh"

module grcw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  grcw_pkg::t_status i_sts,
    output grcw_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DISP    = 4'd1;
    localparam logic [3:0] ST_M0      = 4'd2;
    localparam logic [3:0] ST_M1      = 4'd3;
    localparam logic [3:0] ST_M2      = 4'd4;
    localparam logic [3:0] ST_M3      = 4'd5;
    localparam logic [3:0] ST_M4      = 4'd6;
    localparam logic [3:0] ST_WB      = 4'd7;
    localparam logic [3:0] ST_EMIT    = 4'd8;
    localparam logic [3:0] ST_DR_EMIT = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_j, n_j;
    logic [1:0] w_k;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // rotation j works on slot len-1-j
    assign w_k        = i_sts.eff_len - 2'd1 - r_j;

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        o_cmd   = '0;
        o_cmd.coef_sel = r_j;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DISP;
                end
            end
            ST_DISP: begin
                n_state = ST_IDLE;
                if (i_sts.row_ok) begin
                    case (i_sts.action)
                        grcw_pkg::ACT_PRIME: begin
                            o_cmd.mem_we = i_sts.slot_ok;
                            o_cmd.wr_idx = i_sts.slot;
                        end
                        grcw_pkg::ACT_ROTATE: begin
                            n_j          = 2'd0;
                            o_cmd.mem_re = 1'b1;
                            o_cmd.rd_idx = i_sts.eff_len - 2'd1;
                            n_state      = ST_M0;
                        end
                        grcw_pkg::ACT_DRAIN: begin
                            n_j          = 2'd0;
                            o_cmd.mem_re = 1'b1;
                            o_cmd.rd_idx = 2'd0;
                            n_state      = ST_DR_EMIT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_M0: begin
                // c * h
                n_state = ST_M1;
            end
            ST_M1: begin
                // s * t, acc = rnd + c*h
                o_cmd.mul_sin = 1'b1;
                o_cmd.mul_t   = 1'b1;
                o_cmd.acc_op  = grcw_pkg::ACC_LOAD_ADD;
                n_state       = ST_M2;
            end
            ST_M2: begin
                // s * h, acc += s*t
                o_cmd.mul_sin = 1'b1;
                o_cmd.acc_op  = grcw_pkg::ACC_ADD;
                n_state       = ST_M3;
            end
            ST_M3: begin
                // c * t, keep new t, acc = rnd - s*h
                o_cmd.mul_t   = 1'b1;
                o_cmd.acc_op  = grcw_pkg::ACC_LOAD_SUB;
                o_cmd.tn_load = 1'b1;
                n_state       = ST_M4;
            end
            ST_M4: begin
                o_cmd.acc_op = grcw_pkg::ACC_ADD;
                n_state      = ST_WB;
            end
            ST_WB: begin
                o_cmd.mem_we     = 1'b1;
                o_cmd.wr_src_acc = 1'b1;
                o_cmd.wr_idx     = w_k;
                o_cmd.t_load     = 1'b1;
                if (r_j == i_sts.eff_len - 2'd1) begin
                    n_state = ST_EMIT;
                end else begin
                    // fetch next held slot while this one is written
                    n_j          = r_j + 2'd1;
                    o_cmd.mem_re = 1'b1;
                    o_cmd.rd_idx = w_k - 2'd1;
                    n_state      = ST_M0;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_from_t = 1'b1;
                    o_cmd.out_pos    = 2'd0;
                    o_cmd.out_last   = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_DR_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_pos  = r_j;
                    o_cmd.out_last = (r_j == i_sts.eff_len - 2'd1);
                    if (r_j == i_sts.eff_len - 2'd1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j          = r_j + 2'd1;
                        o_cmd.mem_re = 1'b1;
                        o_cmd.rd_idx = r_j + 2'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_j     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
        end
    end

    `ASSERT_CLK(a_one_item_at_a_time, i_clk, i_rst_n, w_accept |=> !o_in_ready)
    `ASSERT_CLK(a_index_in_chain, i_clk, i_rst_n,
        (r_state != ST_IDLE && r_state != ST_DISP) |-> (r_j < i_sts.eff_len))

endmodule

// File: hdl/grcw_datapath.sv
// Window memory, shared multiply-accumulate unit and output register
`include "assert_macros.svh"

module grcw_datapath #(
    parameter int ROWS       = 12,
    parameter int MAX_CHAIN  = 3,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_wdata,
    input  logic [grcw_pkg::IN_TDATA_W-1:0]    i_tdata,
    input  logic [1:0]                         i_tuser,
    input  grcw_pkg::t_cmd                     i_cmd,
    output grcw_pkg::t_status                  o_sts,
    output logic                               o_tvalid,
    input  logic                               i_tready,
    output logic [grcw_pkg::OUT_TDATA_W-1:0]   o_tdata,
    output logic                               o_tlast
);

    localparam int SW    = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int DEPTH = ROWS * MAX_CHAIN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = 10;
    localparam logic signed [35:0] SAT_HI = (36'sd1 <<< (SW - 1)) - 36'sd1;
    localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;
    localparam logic signed [65:0] RND    = 66'sd1 <<< 29;

    function automatic logic signed [SW-1:0] sat_data(input logic signed [35:0] v);
        logic signed [SW-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[SW-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[SW-1:0];
        else
            r = v[SW-1:0];
        return r;
    endfunction

    logic [1:0]               r_cfg;
    logic [1:0]               r_action;
    logic [3:0]               r_row;
    logic [1:0]               r_slot;
    logic signed [31:0]       r_cos [3];
    logic signed [31:0]       r_sin [3];
    logic signed [SW-1:0]     r_t;
    logic signed [SW-1:0]     r_tn;
    logic signed [SW-1:0]     r_rdata;
    logic signed [SW-1:0]     r_mem [DEPTH];
    logic signed [63:0]       r_prod;
    logic signed [65:0]       r_acc;
    logic                     r_out_valid;
    logic [3:0]               r_out_row;
    logic [1:0]               r_out_pos;
    logic signed [31:0]       r_out_value;
    logic                     r_out_last;

    logic signed [31:0]       w_in_value;
    logic signed [31:0]       w_coef_c;
    logic signed [31:0]       w_coef_s;
    logic signed [31:0]       w_mul_a;
    logic signed [31:0]       w_mul_x;
    logic signed [SW-1:0]     w_acc_sat;
    logic signed [SW-1:0]     w_wr_data;
    logic [FW-1:0]            w_base;
    logic [FW-1:0]            w_wr_full;
    logic [FW-1:0]            w_rd_full;
    logic [AW-1:0]            w_wr_addr;
    logic [AW-1:0]            w_rd_addr;
    logic [1:0]               w_eff_len;
    logic                     w_out_free;

    assign w_in_value = $signed(i_tdata[37:6]);

    // chain length clamped into 1 .. MAX_CHAIN
    always_comb begin
        if (r_cfg == 2'd0)
            w_eff_len = 2'd1;
        else if (32'(r_cfg) > MAX_CHAIN)
            w_eff_len = 2'(MAX_CHAIN);
        else
            w_eff_len = r_cfg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 2'd3;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_tuser;
            r_row    <= i_tdata[3:0];
            r_slot   <= i_tdata[5:4];
            r_cos[0] <= $signed(i_tdata[69:38]);
            r_sin[0] <= $signed(i_tdata[101:70]);
            r_cos[1] <= $signed(i_tdata[133:102]);
            r_sin[1] <= $signed(i_tdata[165:134]);
            r_cos[2] <= $signed(i_tdata[197:166]);
            r_sin[2] <= $signed(i_tdata[229:198]);
            r_t      <= sat_data(36'(w_in_value));
        end else if (i_cmd.t_load) begin
            r_t <= r_tn;
        end
        if (i_cmd.tn_load)
            r_tn <= w_acc_sat;
    end

    always_comb begin
        case (i_cmd.coef_sel)
            2'd0:    begin w_coef_c = r_cos[0]; w_coef_s = r_sin[0]; end
            2'd1:    begin w_coef_c = r_cos[1]; w_coef_s = r_sin[1]; end
            default: begin w_coef_c = r_cos[2]; w_coef_s = r_sin[2]; end
        endcase
    end

    assign w_mul_a   = i_cmd.mul_sin ? w_coef_s : w_coef_c;
    assign w_mul_x   = i_cmd.mul_t ? 32'(r_t) : 32'(r_rdata);
    assign w_acc_sat = sat_data($signed(r_acc[65:30]));

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_x;
        case (i_cmd.acc_op)
            grcw_pkg::ACC_LOAD_ADD: r_acc <= RND + 66'(r_prod);
            grcw_pkg::ACC_LOAD_SUB: r_acc <= RND - 66'(r_prod);
            grcw_pkg::ACC_ADD:      r_acc <= r_acc + 66'(r_prod);
            default:                r_acc <= r_acc;
        endcase
    end

    assign w_base    = FW'(r_row) * FW'(MAX_CHAIN);
    assign w_wr_full = w_base + FW'(i_cmd.wr_idx);
    assign w_rd_full = w_base + FW'(i_cmd.rd_idx);
    assign w_wr_addr = w_wr_full[AW-1:0];
    assign w_rd_addr = w_rd_full[AW-1:0];
    assign w_wr_data = i_cmd.wr_src_acc ? w_acc_sat : r_t;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we)
            r_mem[w_wr_addr] <= w_wr_data;
        if (i_cmd.mem_re)
            r_rdata <= r_mem[w_rd_addr];
    end

    assign w_out_free = !r_out_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row   <= r_row;
            r_out_pos   <= i_cmd.out_pos;
            r_out_value <= i_cmd.out_from_t ? 32'(r_t) : 32'(r_rdata);
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {2'b00, r_out_value, r_out_pos, r_out_row};
    assign o_tlast  = r_out_last;

    assign o_sts.action   = r_action;
    assign o_sts.row_ok   = (32'(r_row) < ROWS);
    assign o_sts.slot     = r_slot;
    assign o_sts.slot_ok  = (32'(r_slot) < MAX_CHAIN);
    assign o_sts.eff_len  = w_eff_len;
    assign o_sts.out_free = w_out_free;

    `ASSERT_CLK(a_no_result_overwrite, i_clk, i_rst_n, i_cmd.out_load |-> w_out_free)
    `ASSERT_CLK(a_rw_apart, i_clk, i_rst_n,
        (i_cmd.mem_we && i_cmd.mem_re) |-> (i_cmd.wr_idx != i_cmd.rd_idx))

endmodule

// File: hdl/givens_rotation_chain_wavefront_top.sv
// Top level of the Givens rotation wavefront block
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata fields, tuser action
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata fields, tlast last
//  cfg       in         i_cfg_we                       i_cfg_wdata chain length
//
// One item at a time. With L the clamped chain length, a rotate item runs
// its L rotations in turn through the single shared 32x32 multiplier,
// doing four products per rotation, then emits the new t; drain emits the
// L held slots in order. Synchronous active-low reset; the window
// memory is not cleared. A stalled output holds one result in the output
// register and the sequencer waits before loading the next.
module givens_rotation_chain_wavefront_top #(
    parameter int ROWS       = 12,
    parameter int MAX_CHAIN  = 3,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row, slot, value, cos_first, sin_first, cos_second, sin_second,
    // cos_third, sin_third, zero pad
    input  logic [grcw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // action
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_row, out_position, out_value, zero pad
    output logic [grcw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast
);

    grcw_pkg::t_cmd    w_cmd;
    grcw_pkg::t_status w_sts;

    grcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    grcw_datapath #(
        .ROWS       (ROWS),
        .MAX_CHAIN  (MAX_CHAIN),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

endmodule
